>>> design/wsm_pkg.sv
// Shared constants, types and helpers for the wavetable sample mixer.
package wsm_pkg;

    localparam int NUM_CHANNELS     = 4;
    localparam int SAMPLE_MEM_BYTES = 65536;

    localparam int MEM_AW    = $clog2(SAMPLE_MEM_BYTES);
    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W     = $clog2(NUM_CHANNELS + 1);
    localparam int ADDR_W    = 16;
    localparam int POS_W     = 28;
    localparam int STEP_W    = 20;
    localparam int GAIN_W    = 7;
    localparam int SMP_W     = 8;
    localparam int ACC_W     = 16;
    localparam int FRAC_BITS = 12;
    localparam int OUT_SHIFT = 8;
    localparam int OUT_W     = ACC_W - OUT_SHIFT;
    localparam int ACT_W     = 4;
    localparam int DVD_W     = POS_W + 1;
    localparam int DCNT_W    = $clog2(DVD_W + 1);

    typedef enum logic [1:0] {
        MODE_WRITE,
        MODE_START,
        MODE_MIX
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MAC,
        S_CHK,
        S_DIV,
        S_WRAP,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_status;

    function automatic logic [MEM_AW-1:0] to_mem_addr(input logic [ADDR_W-1:0] a);
        logic [31:0] t;
        t = 32'(a);
        return t[MEM_AW-1:0];
    endfunction

endpackage

>>> design/wsm_sample_ram.sv
// Sample byte memory: one write port, one registered read port.
module wsm_sample_ram import wsm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [MEM_AW-1:0] i_wr_addr,
    input  logic [SMP_W-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [MEM_AW-1:0] i_rd_addr,
    output logic [SMP_W-1:0]  o_rd_data
);

    logic [SMP_W-1:0] r_mem [SAMPLE_MEM_BYTES];
    logic [SMP_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/wsm_rem_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module wsm_rem_unit import wsm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [POS_W-1:0] i_divisor,
    output logic [POS_W-1:0] o_rem,
    output t_rem_status      o_status
);

    logic [DCNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [POS_W-1:0]  r_div;
    logic [POS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  trial;
    logic [POS_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = POS_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = POS_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rem         = r_rem;
    assign o_status.busy = (r_cnt != '0);
    assign o_status.done = (r_cnt == DCNT_W'(1));

endmodule

>>> design/wavetable_sample_mixer_unit.sv
// Four-channel wavetable mixer: sample memory, channel state and mix sequencer.
//
// A write or start item is taken without leaving the idle state. A mix
// item visits the channels in order under a small sequencer: an inactive
// channel is skipped, an active one goes through a memory read, a
// multiply-accumulate and a position check, and a channel that reaches
// its end with a nonzero loop length then passes through the bit-serial
// remainder unit that wraps its position back. A mix keeps the input
// closed until the sequencer is idle again. The result lands in an
// output register, so the next item is taken as soon as the sequencer
// is idle even if the result is still waiting to be taken; a later mix
// holds in its last step for as long as the earlier result is still
// waiting. Reading a sample byte never written returns whatever the
// memory holds.
module wavetable_sample_mixer_unit import wsm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_mode,
    input  logic [ADDR_W-1:0]        i_address,
    input  logic signed [SMP_W-1:0]  i_sample_byte,
    input  logic [1:0]               i_channel,
    input  logic [POS_W-1:0]         i_end_position,
    input  logic [POS_W-1:0]         i_loop_length,
    input  logic [STEP_W-1:0]        i_step,
    input  logic [GAIN_W-1:0]        i_volume,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [OUT_W-1:0]  o_mixed_sample,
    output logic [ACT_W-1:0]         o_active_channels
);

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_ch, n_ch;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [DVD_W-1:0]  r_pos, n_pos;
    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_mixed;
    logic [ACT_W-1:0]  r_act;

    logic [ADDR_W-1:0] r_start [NUM_CHANNELS];
    logic [POS_W-1:0]  r_position [NUM_CHANNELS];
    logic [POS_W-1:0]  r_end [NUM_CHANNELS];
    logic [POS_W-1:0]  r_loop [NUM_CHANNELS];
    logic [STEP_W-1:0] r_step [NUM_CHANNELS];
    logic [GAIN_W-1:0] r_gain [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_active;

    logic [CH_W-1:0]   ch_idx;
    logic [CH_W-1:0]   ch_wr;
    logic [ADDR_W-1:0] cur_start;
    logic [POS_W-1:0]  cur_pos;
    logic [POS_W-1:0]  cur_end;
    logic [POS_W-1:0]  cur_loop;
    logic [STEP_W-1:0] cur_step;
    logic [GAIN_W-1:0] cur_gain;
    logic [ADDR_W-1:0] rd_idx;
    logic [SMP_W-1:0]  rd_data;
    logic signed [ACC_W-1:0] prod;
    logic [DVD_W-1:0]  wrap_sum;
    logic [POS_W-1:0]  rem;
    t_rem_status       rem_status;

    logic in_xfer;
    logic mem_we;
    logic start_we;
    logic rd_en;
    logic rem_start;
    logic pos_we;
    logic [POS_W-1:0] pos_val;
    logic act_clr;
    logic push;
    logic [ACT_W-1:0] act_vec;

    assign ch_idx    = r_ch[CH_W-1:0];
    assign ch_wr     = CH_W'(i_channel);
    assign cur_start = r_start[ch_idx];
    assign cur_pos   = r_position[ch_idx];
    assign cur_end   = r_end[ch_idx];
    assign cur_loop  = r_loop[ch_idx];
    assign cur_step  = r_step[ch_idx];
    assign cur_gain  = r_gain[ch_idx];

    assign rd_idx   = cur_start + cur_pos[POS_W-1:FRAC_BITS];
    assign prod     = $signed(rd_data) * $signed({1'b0, cur_gain});
    assign wrap_sum = {1'b0, cur_end} + {1'b0, rem};

    assign in_xfer  = i_valid && o_ready;
    assign mem_we   = in_xfer && (i_mode == MODE_WRITE);
    assign start_we = in_xfer && (i_mode == MODE_START) && (32'(i_channel) < NUM_CHANNELS);

    wsm_sample_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (to_mem_addr(i_address)),
        .i_wr_data (i_sample_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (to_mem_addr(rd_idx)),
        .o_rd_data (rd_data)
    );

    wsm_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_pos - {1'b0, cur_end}),
        .i_divisor  (cur_loop),
        .o_rem      (rem),
        .o_status   (rem_status)
    );

    always_comb begin
        act_vec = '0;
        for (int c = 0; c < ACT_W; c++) begin
            if (c < NUM_CHANNELS) begin
                act_vec[c] = r_active[c];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_ready;
        o_ready     = 1'b0;
        rd_en       = 1'b0;
        rem_start   = 1'b0;
        pos_we      = 1'b0;
        pos_val     = r_pos[POS_W-1:0];
        act_clr     = 1'b0;
        push        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && (i_mode == MODE_MIX)) begin
                    n_state = S_SCAN;
                    n_ch    = '0;
                    n_acc   = '0;
                end
            end
            S_SCAN: begin
                if (r_ch == CNT_W'(NUM_CHANNELS)) begin
                    n_state = S_PUSH;
                end else if (r_active[ch_idx]) begin
                    rd_en   = 1'b1;
                    n_state = S_MAC;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            S_MAC: begin
                n_acc   = r_acc + prod;
                n_pos   = {1'b0, cur_pos} + DVD_W'(cur_step);
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_pos >= {1'b0, cur_end}) begin
                    if (cur_loop == '0) begin
                        act_clr = 1'b1;
                        pos_we  = 1'b1;
                        n_ch    = r_ch + 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        rem_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end else begin
                    pos_we  = 1'b1;
                    n_ch    = r_ch + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_DIV: begin
                if (rem_status.done) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                pos_we = 1'b1;
                if (wrap_sum < {1'b0, cur_loop}) begin
                    pos_val = '0;
                end else begin
                    pos_val = POS_W'(wrap_sum - {1'b0, cur_loop});
                end
                n_ch    = r_ch + 1'b1;
                n_state = S_SCAN;
            end
            S_PUSH: begin
                if (!r_out_valid || i_ready) begin
                    push        = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            r_active    <= '0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
            if (start_we) begin
                r_active[ch_wr] <= 1'b1;
            end else if (act_clr) begin
                r_active[ch_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_pos <= n_pos;
        if (push) begin
            r_mixed <= r_acc[ACC_W-1:OUT_SHIFT];
            r_act   <= act_vec;
        end
        if (start_we) begin
            r_start[ch_wr]    <= i_address;
            r_end[ch_wr]      <= i_end_position;
            r_loop[ch_wr]     <= i_loop_length;
            r_step[ch_wr]     <= i_step;
            r_gain[ch_wr]     <= i_volume;
            r_position[ch_wr] <= '0;
        end else if (pos_we) begin
            r_position[ch_idx] <= pos_val;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_mixed_sample    = r_mixed;
    assign o_active_channels = r_act;

endmodule

>>> design/wsm_checker.sv
// Port-level checks for the wavetable sample mixer, bound to the top level.
module wsm_checker import wsm_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic [1:0]               i_mode,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic signed [OUT_W-1:0]  o_mixed_sample,
    input logic [ACT_W-1:0]         o_active_channels
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mixed_sample)
            && $stable(o_active_channels))
        else $error("result dropped or changed while stalled");

    a_mix_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_mode == MODE_MIX) |=> !o_ready)
        else $error("ready after mix transfer");

    a_other_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_mode != MODE_MIX) |=> o_ready)
        else $error("not ready after single-cycle transfer");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind wavetable_sample_mixer_unit wsm_checker u_wsm_checker (.*);

>>> tb/tb_wavetable_sample_mixer_unit.sv
// Self-checking testbench for the four-channel wavetable sample mixer.
module tb_wavetable_sample_mixer_unit import wsm_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_RESERVED = 2'b11;
    localparam int RANDOM_ITEMS = 1950;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [SMP_W-1:0]  sbyte;
        logic [1:0]        channel;
        logic [POS_W-1:0]  end_pos;
        logic [POS_W-1:0]  loop_len;
        logic [STEP_W-1:0] step;
        logic [GAIN_W-1:0] volume;
    } t_mixer_item;

    typedef struct packed {
        logic [OUT_W-1:0] mixed;
        logic [ACT_W-1:0] active;
    } t_mixed_sample;

    class t_mix_scoreboard;
        logic [SMP_W-1:0]  sample_mem [SAMPLE_MEM_BYTES];
        bit                written [SAMPLE_MEM_BYTES];
        logic [ADDR_W-1:0] chan_base [NUM_CHANNELS];
        logic [POS_W-1:0]  chan_pos [NUM_CHANNELS];
        logic [POS_W-1:0]  chan_lim [NUM_CHANNELS];
        logic [POS_W-1:0]  chan_loop [NUM_CHANNELS];
        logic [STEP_W-1:0] chan_step [NUM_CHANNELS];
        logic [GAIN_W-1:0] chan_gain [NUM_CHANNELS];
        bit                chan_on [NUM_CHANNELS];
        t_mixed_sample     pending_samples [$];
        int                mismatches;

        function new();
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                chan_base[c] = '0;
                chan_pos[c]  = '0;
                chan_lim[c]  = '0;
                chan_loop[c] = '0;
                chan_step[c] = '0;
                chan_gain[c] = '0;
                chan_on[c]   = 1'b0;
            end
            mismatches = 0;
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction

        function logic [ADDR_W-1:0] read_addr(int c);
            return chan_base[c] + ADDR_W'(chan_pos[c] >> FRAC_BITS);
        endfunction

        function bit find_unwritten(output logic [ADDR_W-1:0] addr);
            addr = '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (chan_on[c] && !written[read_addr(c)]) begin
                    addr = read_addr(c);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_item(t_mixer_item it);
            logic [ACC_W-1:0] acc;
            logic [ACT_W-1:0] act;
            int prod;
            longint unsigned npos, lim, lp, k, back;
            t_mixed_sample res;
            case (it.mode)
                MODE_WRITE: begin
                    sample_mem[it.address] = it.sbyte;
                    written[it.address] = 1'b1;
                end
                MODE_START: begin
                    chan_base[it.channel] = it.address;
                    chan_lim[it.channel]  = it.end_pos;
                    chan_loop[it.channel] = it.loop_len;
                    chan_step[it.channel] = it.step;
                    chan_gain[it.channel] = it.volume;
                    chan_pos[it.channel]  = '0;
                    chan_on[it.channel]   = 1'b1;
                end
                MODE_MIX: begin
                    acc = '0;
                    act = '0;
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (chan_on[c]) begin
                            prod = int'($signed(sample_mem[read_addr(c)])) * int'(chan_gain[c]);
                            acc = acc + prod[ACC_W-1:0];
                            npos = 64'(chan_pos[c]) + 64'(chan_step[c]);
                            lim = 64'(chan_lim[c]);
                            lp = 64'(chan_loop[c]);
                            if (npos >= lim) begin
                                if (lp == 0) begin
                                    chan_on[c] = 1'b0;
                                end else begin
                                    k = (npos - lim) / lp + 1;
                                    back = k * lp;
                                    npos = (back > npos) ? 64'd0 : npos - back;
                                end
                            end
                            chan_pos[c] = npos[POS_W-1:0];
                        end
                    end
                    for (int c = 0; c < NUM_CHANNELS && c < ACT_W; c++) begin
                        act[c] = chan_on[c];
                    end
                    res.mixed = acc[ACC_W-1:OUT_SHIFT];
                    res.active = act;
                    pending_samples.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_sample(logic [OUT_W-1:0] mixed, logic [ACT_W-1:0] active);
            t_mixed_sample want;
            if (pending_samples.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: mixed_sample=%0d active_channels=%b",
                         $time, $signed(mixed), active);
                return;
            end
            want = pending_samples.pop_front();
            if (mixed !== want.mixed) begin
                mismatches++;
                $display("%0t: mixed_sample expected %0d, actual %0d",
                         $time, $signed(want.mixed), $signed(mixed));
            end
            if (active !== want.active) begin
                mismatches++;
                $display("%0t: active_channels expected %b, actual %b",
                         $time, want.active, active);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [1:0]              i_mode;
    logic [ADDR_W-1:0]       i_address;
    logic signed [SMP_W-1:0] i_sample_byte;
    logic [1:0]              i_channel;
    logic [POS_W-1:0]        i_end_position;
    logic [POS_W-1:0]        i_loop_length;
    logic [STEP_W-1:0]       i_step;
    logic [GAIN_W-1:0]       i_volume;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [OUT_W-1:0] o_mixed_sample;
    logic [ACT_W-1:0]        o_active_channels;

    t_mix_scoreboard sb;
    bit              steady;
    int              transfers;
    int              quiet_cycles;

    wavetable_sample_mixer_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_address         (i_address),
        .i_sample_byte     (i_sample_byte),
        .i_channel         (i_channel),
        .i_end_position    (i_end_position),
        .i_loop_length     (i_loop_length),
        .i_step            (i_step),
        .i_volume          (i_volume),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_mixed_sample    (o_mixed_sample),
        .o_active_channels (o_active_channels)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 13);
    endfunction

    function automatic t_mixer_item random_item(logic [1:0] mode);
        t_mixer_item it;
        it.mode     = mode;
        it.address  = ADDR_W'($urandom);
        it.sbyte    = SMP_W'($urandom);
        it.channel  = 2'($urandom);
        it.end_pos  = POS_W'($urandom);
        it.loop_len = POS_W'($urandom);
        it.step     = STEP_W'($urandom);
        it.volume   = GAIN_W'($urandom);
        return it;
    endfunction

    task automatic send_item(t_mixer_item it);
        while (take_break()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= it.mode;
        i_address      <= it.address;
        i_sample_byte  <= it.sbyte;
        i_channel      <= it.channel;
        i_end_position <= it.end_pos;
        i_loop_length  <= it.loop_len;
        i_step         <= it.step;
        i_volume       <= it.volume;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_item(it);
        if (it.mode != MODE_RESERVED) transfers++;
    endtask

    task automatic write_byte(logic [ADDR_W-1:0] addr, logic [SMP_W-1:0] value);
        t_mixer_item it;
        it = random_item(MODE_WRITE);
        it.address = addr;
        it.sbyte = value;
        send_item(it);
    endtask

    task automatic start_channel(logic [1:0] ch, logic [ADDR_W-1:0] base,
                                 logic [POS_W-1:0] lim, logic [POS_W-1:0] lp,
                                 logic [STEP_W-1:0] stp, logic [GAIN_W-1:0] vol);
        t_mixer_item it;
        it = random_item(MODE_START);
        it.channel  = ch;
        it.address  = base;
        it.end_pos  = lim;
        it.loop_len = lp;
        it.step     = stp;
        it.volume   = vol;
        send_item(it);
    endtask

    task automatic mix_once();
        logic [ADDR_W-1:0] hole;
        while (sb.find_unwritten(hole)) write_byte(hole, SMP_W'($urandom));
        send_item(random_item(MODE_MIX));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic start_random();
        logic [POS_W-1:0]  lim, lp;
        logic [STEP_W-1:0] stp;
        logic [GAIN_W-1:0] vol;
        case ($urandom_range(0, 9))
            0:       lim = '0;
            1:       lim = POS_W'($urandom);
            default: lim = POS_W'($urandom_range(1, 1 << 17));
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2: lp = '0;
            3:       lp = POS_W'($urandom);
            4:       lp = lim + POS_W'($urandom_range(1, 1 << FRAC_BITS));
            default: lp = POS_W'($urandom_range(1, (lim == 0) ? 1 : int'(lim)));
        endcase
        case ($urandom_range(0, 9))
            0:       stp = '0;
            1:       stp = STEP_W'($urandom);
            default: stp = STEP_W'($urandom_range(0, 1 << 13));
        endcase
        vol = ($urandom_range(0, 7) == 0) ? GAIN_W'($urandom_range(65, 127))
                                          : GAIN_W'($urandom_range(0, 64));
        start_channel(2'($urandom), ADDR_W'($urandom), lim, lp, stp, vol);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            sb.check_sample(o_mixed_sample, o_active_channels);
        i_ready <= !take_break();
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int pick;
        sb = new();
        steady = 1'b0;
        transfers = 0;
        quiet_cycles = 0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_ready        <= 1'b0;
        i_mode         <= MODE_WRITE;
        i_address      <= '0;
        i_sample_byte  <= '0;
        i_channel      <= '0;
        i_end_position <= '0;
        i_loop_length  <= '0;
        i_step         <= '0;
        i_volume       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        mix_once();
        send_item(random_item(MODE_RESERVED));
        write_byte(16'h0000, 8'h80);
        write_byte(16'hFFFF, 8'h7F);
        start_channel(2'd0, 16'hFFFF, POS_W'(3 << FRAC_BITS), '0,
                      STEP_W'(1 << FRAC_BITS), 7'd64);
        start_channel(2'd1, 16'h0000, '0, '1, '1, 7'd127);
        start_channel(2'd2, 16'hFFFF, '1, '0, '0, 7'd0);
        start_channel(2'd3, 16'h0000, POS_W'(5 << FRAC_BITS), POS_W'(2 << FRAC_BITS),
                      STEP_W'(3 << FRAC_BITS), 7'd100);
        repeat (8) mix_once();
        drain_results();

        transfers = 0;
        start_channel(2'd3, ADDR_W'($urandom), '1, POS_W'($urandom_range(1, 1 << 16)),
                      '1, GAIN_W'($urandom));
        repeat (270) mix_once();

        while (transfers < RANDOM_ITEMS) begin
            steady = (transfers >= 900 && transfers < 1200);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                mix_once();
            else if (pick < 70)
                start_random();
            else if (pick < 92)
                write_byte(ADDR_W'($urandom), SMP_W'($urandom));
            else if (pick < 97)
                send_item(random_item(MODE_RESERVED));
            else if (pick < 98)
                drain_results();
            else
                repeat ($urandom_range(2, 12)) mix_once();
        end
        steady = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
design/wsm_pkg.sv
design/wsm_sample_ram.sv
design/wsm_rem_unit.sv
design/wavetable_sample_mixer_unit.sv
design/wsm_checker.sv
tb/tb_wavetable_sample_mixer_unit.sv
